FILE: rtl/core/mcc_pkg.sv
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared widths, codes and interface structs of the minimum coin change block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

    // Sizing
    localparam int MAX_COINS  = 16;
    localparam int MAX_AMOUNT = 1023;

    // Field widths
    localparam int CMD_W  = 1;
    localparam int IDX_W  = 4;
    localparam int COIN_W = 10;
    localparam int TGT_W  = 10;
    localparam int MINC_W = 10;
    localparam int CCNT_W = 5;

    // Derived storage widths
    localparam int CIDX_W = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int USED_W = $clog2(MAX_COINS + 1);
    localparam int AW     = $clog2(MAX_AMOUNT + 1);
    localparam int CNT_W  = 11;

    // Saturating marker for an amount that cannot be made
    localparam logic [CNT_W-1:0] INF_MARK = {CNT_W{1'b1}};

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    typedef struct packed {
        logic              we;
        logic [CIDX_W-1:0] waddr;
        logic [COIN_W-1:0] wdata;
        logic [CIDX_W-1:0] raddr;
    } t_coin_req;

    typedef struct packed {
        logic             we;
        logic [AW-1:0]    waddr;
        logic [CNT_W-1:0] wdata;
        logic [AW-1:0]    raddr_a;
        logic [AW-1:0]    raddr_b;
    } t_row_req;

    typedef struct packed {
        logic              valid;
        logic [MINC_W-1:0] min_coins;
        logic              reachable;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/mcc_ram.sv
// ----------------------------------------------------------------------------
// mcc_ram
// Single-port-write, single-port-read synchronous RAM with a registered read,
// write-first on a same-address collision.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Forward the write data when the same entry is read in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/mcc_ctrl.sv
// ----------------------------------------------------------------------------
// mcc_ctrl
// Sequencer of the coin change block: coin loads, row initialization,
// per-coin read-modify-write sweep of the best count row, result read.
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mcc_pkg::CMD_W-1:0]   i_command,
    input  wire logic [mcc_pkg::IDX_W-1:0]   i_coin_index,
    input  wire logic [mcc_pkg::COIN_W-1:0]  i_coin_value,
    input  wire logic [mcc_pkg::TGT_W-1:0]   i_target_amount,
    input  wire logic [mcc_pkg::USED_W-1:0]  i_used,
    input  wire logic                        i_out_free,
    input  wire logic [mcc_pkg::COIN_W-1:0]  i_coin_rd,
    input  wire logic [mcc_pkg::CNT_W-1:0]   i_row_rd_a,
    input  wire logic [mcc_pkg::CNT_W-1:0]   i_row_rd_b,
    output mcc_pkg::t_coin_req               o_coin_req,
    output mcc_pkg::t_row_req                o_row_req,
    output mcc_pkg::t_result                 o_res
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_INIT     = 7'b0000010,
        S_COIN_RD  = 7'b0000100,
        S_COIN_CHK = 7'b0001000,
        S_UPD      = 7'b0010000,
        S_FIN_RD   = 7'b0100000,
        S_FIN      = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic [mcc_pkg::AW-1:0]        r_a, n_a;
    logic [mcc_pkg::USED_W-1:0]    r_c, n_c;
    logic [mcc_pkg::USED_W-1:0]    r_used, n_used;
    logic [mcc_pkg::COIN_W-1:0]    r_coin, n_coin;
    logic [mcc_pkg::AW-1:0]        r_target, n_target;
    logic                          r_iss, n_iss;
    logic                          r_s1_valid, n_s1_valid;
    logic [mcc_pkg::AW-1:0]        r_s1_addr, n_s1_addr;
    logic                          r_none, n_none;

    logic                          accept;
    logic [mcc_pkg::USED_W-1:0]    c_next;
    logic                          last_coin;
    logic                          coin_skip;
    logic [mcc_pkg::CNT_W-1:0]     cand;
    logic [mcc_pkg::CNT_W-1:0]     best;
    logic                          row_reach;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign c_next     = mcc_pkg::USED_W'(r_c + 1'b1);
    assign last_coin  = (c_next == r_used);
    assign coin_skip  = (i_coin_rd == '0) || (32'(i_coin_rd) > 32'(r_target));

    // Candidate from amount a-coin, saturating at the marker
    assign cand = (i_row_rd_a >= mcc_pkg::INF_MARK) ? mcc_pkg::INF_MARK
                                                     : mcc_pkg::CNT_W'(i_row_rd_a + 1'b1);
    assign best = (cand < i_row_rd_b) ? cand : i_row_rd_b;
    assign row_reach = (i_row_rd_a < mcc_pkg::INF_MARK);

    // Coin table access
    always_comb begin
        o_coin_req.we    = accept && (i_command == mcc_pkg::CMD_LOAD)
                           && (32'(i_coin_index) < mcc_pkg::MAX_COINS);
        o_coin_req.waddr = mcc_pkg::CIDX_W'(i_coin_index);
        o_coin_req.wdata = i_coin_value;
        o_coin_req.raddr = r_c[mcc_pkg::CIDX_W-1:0];
    end

    // Row access
    always_comb begin
        o_row_req.raddr_b = r_a;
        if ((r_state == S_FIN_RD) || (r_state == S_FIN)) begin
            o_row_req.raddr_a = r_target;
        end else begin
            o_row_req.raddr_a = r_a - mcc_pkg::AW'(r_coin);
        end
        case (r_state)
            S_INIT: begin
                o_row_req.we    = 1'b1;
                o_row_req.waddr = r_a;
                o_row_req.wdata = (r_a == '0) ? '0 : mcc_pkg::INF_MARK;
            end
            S_UPD: begin
                o_row_req.we    = r_s1_valid;
                o_row_req.waddr = r_s1_addr;
                o_row_req.wdata = best;
            end
            default: begin
                o_row_req.we    = 1'b0;
                o_row_req.waddr = r_s1_addr;
                o_row_req.wdata = best;
            end
        endcase
    end

    // Result
    always_comb begin
        o_res.valid     = (r_state == S_FIN);
        o_res.reachable = !r_none && row_reach;
        o_res.min_coins = o_res.reachable ? mcc_pkg::MINC_W'(i_row_rd_a) : '0;
    end

    always_comb begin
        n_state    = r_state;
        n_a        = r_a;
        n_c        = r_c;
        n_used     = r_used;
        n_coin     = r_coin;
        n_target   = r_target;
        n_iss      = r_iss;
        n_s1_valid = 1'b0;
        n_s1_addr  = r_s1_addr;
        n_none     = r_none;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == mcc_pkg::CMD_QUERY)) begin
                    n_target = mcc_pkg::AW'(i_target_amount);
                    n_used   = i_used;
                    n_a      = '0;
                    if ((i_used == '0) || (32'(i_target_amount) > mcc_pkg::MAX_AMOUNT)) begin
                        n_none  = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_none  = 1'b0;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_a = mcc_pkg::AW'(r_a + 1'b1);
                if (r_a == r_target) begin
                    n_c     = '0;
                    n_state = S_COIN_RD;
                end
            end
            S_COIN_RD: begin
                n_state = S_COIN_CHK;
            end
            S_COIN_CHK: begin
                if (coin_skip) begin
                    n_c     = c_next;
                    n_state = last_coin ? S_FIN_RD : S_COIN_RD;
                end else begin
                    n_coin  = i_coin_rd;
                    n_a     = mcc_pkg::AW'(i_coin_rd);
                    n_iss   = 1'b1;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_iss) begin
                    n_a        = mcc_pkg::AW'(r_a + 1'b1);
                    n_s1_valid = 1'b1;
                    n_s1_addr  = r_a;
                    if (r_a == r_target) begin
                        n_iss = 1'b0;
                    end
                end else if (!r_s1_valid) begin
                    n_c     = c_next;
                    n_state = last_coin ? S_FIN_RD : S_COIN_RD;
                end
            end
            S_FIN_RD: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_iss      <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_iss      <= n_iss;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_c       <= n_c;
        r_used    <= n_used;
        r_coin    <= n_coin;
        r_target  <= n_target;
        r_s1_addr <= n_s1_addr;
        r_none    <= n_none;
    end

`ifndef ASSERT_OFF
    a_s1_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_s1_addr <= r_target))
        else $error("row update beyond target amount");

    a_issue_above_coin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && r_iss) |-> (32'(r_a) >= 32'(r_coin)))
        else $error("row sweep address below coin value");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_command == mcc_pkg::CMD_QUERY)) |=> (r_state != S_IDLE))
        else $error("query transaction dropped");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_coin_req.we |-> (r_state == S_IDLE))
        else $error("coin load while a query runs");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/min_coin_change_dp_top.sv
// ----------------------------------------------------------------------------
// min_coin_change_dp_top
// Minimum coin change engine: coin table, best count row and output register.
// ----------------------------------------------------------------------------
// A load transaction (command 0) stores one denomination in a coin slot; it
// gives no result. A query transaction (command 1) builds the best count row
// in RAM and returns the fewest coins for the target plus a reachable flag.
// The row RAM is swept once per usable coin at one read-modify-write per
// cycle; the single write port of the row RAM sets that rate. Input is
// stalled while a query runs; loads and the next query are taken while a
// finished result still waits in the output register. Write coin_count only
// while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change_dp_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [mcc_pkg::CCNT_W-1:0]  i_cfg_wdata,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mcc_pkg::CMD_W-1:0]   i_command,
    input  wire logic [mcc_pkg::IDX_W-1:0]   i_coin_index,
    input  wire logic [mcc_pkg::COIN_W-1:0]  i_coin_value,
    input  wire logic [mcc_pkg::TGT_W-1:0]   i_target_amount,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [mcc_pkg::MINC_W-1:0]       o_min_coins,
    output logic                             o_reachable
);

    logic [mcc_pkg::CCNT_W-1:0]  r_coin_count;
    logic [mcc_pkg::USED_W-1:0]  used;

    logic                        r_o_valid;
    logic [mcc_pkg::MINC_W-1:0]  r_o_min;
    logic                        r_o_reach;
    logic                        out_free;

    mcc_pkg::t_coin_req          coin_req;
    mcc_pkg::t_row_req           row_req;
    mcc_pkg::t_result            res;
    logic [mcc_pkg::COIN_W-1:0]  coin_rd;
    logic [mcc_pkg::CNT_W-1:0]   row_rd_a;
    logic [mcc_pkg::CNT_W-1:0]   row_rd_b;

    // Hold the coin count register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coin_count <= '0;
        end else if (i_cfg_we) begin
            r_coin_count <= i_cfg_wdata;
        end
    end

    // Clamp the count to the slots that exist
    assign used = (32'(r_coin_count) > mcc_pkg::MAX_COINS)
                  ? mcc_pkg::USED_W'(mcc_pkg::MAX_COINS)
                  : mcc_pkg::USED_W'(r_coin_count);

    // The output register is free when empty or being drained this cycle
    assign out_free = !r_o_valid || !i_out_stall;

    mcc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_coin_index    (i_coin_index),
        .i_coin_value    (i_coin_value),
        .i_target_amount (i_target_amount),
        .i_used          (used),
        .i_out_free      (out_free),
        .i_coin_rd       (coin_rd),
        .i_row_rd_a      (row_rd_a),
        .i_row_rd_b      (row_rd_b),
        .o_coin_req      (coin_req),
        .o_row_req       (row_req),
        .o_res           (res)
    );

    // Coin denominations
    mcc_ram #(
        .WIDTH (mcc_pkg::COIN_W),
        .DEPTH (mcc_pkg::MAX_COINS)
    ) u_coin_ram (
        .i_clk   (i_clk),
        .i_we    (coin_req.we),
        .i_waddr (coin_req.waddr),
        .i_wdata (coin_req.wdata),
        .i_raddr (coin_req.raddr),
        .o_rdata (coin_rd)
    );

    // Best count row, duplicated to give two read ports: amount minus coin
    // on port A, the entry being updated on port B
    mcc_ram #(
        .WIDTH (mcc_pkg::CNT_W),
        .DEPTH (mcc_pkg::MAX_AMOUNT + 1)
    ) u_row_ram_a (
        .i_clk   (i_clk),
        .i_we    (row_req.we),
        .i_waddr (row_req.waddr),
        .i_wdata (row_req.wdata),
        .i_raddr (row_req.raddr_a),
        .o_rdata (row_rd_a)
    );

    mcc_ram #(
        .WIDTH (mcc_pkg::CNT_W),
        .DEPTH (mcc_pkg::MAX_AMOUNT + 1)
    ) u_row_ram_b (
        .i_clk   (i_clk),
        .i_we    (row_req.we),
        .i_waddr (row_req.waddr),
        .i_wdata (row_req.wdata),
        .i_raddr (row_req.raddr_b),
        .o_rdata (row_rd_b)
    );

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (res.valid && out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && out_free) begin
            r_o_min   <= res.min_coins;
            r_o_reach <= res.reachable;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_min_coins = r_o_min;
    assign o_reachable = r_o_reach;

endmodule

`default_nettype wire
